### rtl/csm_pkg.sv
// Package of shared widths, register indexes, colormap codes and colormap endpoints.
package csm_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int FRAC_W       = 16;
    localparam int COLOR_W      = 8;
    localparam int MAX_LEVELS   = 256;
    localparam int LEVEL_W      = 9;
    localparam int MAP_W        = 3;
    localparam int SAMPLE_POINT = 16;
    localparam int LOG_INT_W    = 6;
    localparam int LOG_W        = LOG_INT_W + FRAC_W;
    localparam int LOG_LAT      = FRAC_W + 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int PCT_W        = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_SELECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING    = 3'd5;

    localparam logic [MAP_W-1:0] MAP_SOLID   = 3'd0;
    localparam logic [MAP_W-1:0] MAP_GRAY    = 3'd1;
    localparam logic [MAP_W-1:0] MAP_VIRIDIS = 3'd2;
    localparam logic [MAP_W-1:0] MAP_PLASMA  = 3'd3;
    localparam logic [MAP_W-1:0] MAP_TURBO   = 3'd4;

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_valid;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        logic               is_missing;
    } out_item_t;

    typedef struct packed {
        logic [PCT_W-1:0] r;
        logic [PCT_W-1:0] g;
        logic [PCT_W-1:0] b;
    } rgb_pct_t;

    typedef struct packed {
        rgb_pct_t lo_end;
        rgb_pct_t hi_end;
    } blend_t;

    // Endpoints in hundredths of full scale; undefined codes fall back to viridis.
    function automatic blend_t map_blend(input logic [MAP_W-1:0] sel);
        blend_t ep;
        unique case (sel)
            MAP_SOLID: ep = '{'{7'd20, 7'd65, 7'd100}, '{7'd20, 7'd65, 7'd100}};
            MAP_GRAY:  ep = '{'{7'd0, 7'd0, 7'd0}, '{7'd100, 7'd100, 7'd100}};
            MAP_PLASMA: ep = '{'{7'd5, 7'd3, 7'd53}, '{7'd94, 7'd98, 7'd13}};
            MAP_TURBO: ep = '{'{7'd19, 7'd7, 7'd23}, '{7'd48, 7'd2, 7'd1}};
            default:   ep = '{'{7'd27, 7'd0, 7'd33}, '{7'd99, 7'd91, 7'd14}};
        endcase
        return ep;
    endfunction

endpackage

### rtl/csm_stream_if.sv
// Valid/ready stream interface carrying one typed payload per transfer.
interface csm_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/csm_log2.sv
// Pipelined fixed-point log2: leading-one search, normalisation and one squaring per stage.
module csm_log2 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [csm_pkg::SAMPLE_W-1:0]  x,
    output logic [csm_pkg::LOG_W-1:0]     result
);
    localparam int SW = csm_pkg::SAMPLE_W;
    localparam int PW = $clog2(SW);
    localparam int FW = csm_pkg::FRAC_W;
    localparam int IW = csm_pkg::LOG_INT_W;
    localparam int MW = SW - 1;

    logic [PW-1:0] msb_c;
    logic [SW-1:0] x_reg;
    logic [PW-1:0] msb_reg;
    logic [PW-1:0] shamt;
    logic [SW-1:0] norm;

    logic [MW-1:0] m_reg    [0:FW-1];
    logic [IW-1:0] ip_reg   [0:FW];
    logic [FW-1:0] frac_reg [0:FW];

    always_comb
    begin
        msb_c = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (x[i])
            begin
                msb_c = PW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x;
            msb_reg <= msb_c;
        end
    end

    assign shamt = PW'(SW - 1) - msb_reg;
    assign norm  = x_reg << shamt;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= norm[SW-1:1];
            ip_reg[0]   <= IW'(msb_reg) - IW'(csm_pkg::SAMPLE_POINT);
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < FW; k++)
    begin : g_square
        logic [2*MW-1:0] sq;
        logic [MW:0]     t;

        assign sq = m_reg[k] * m_reg[k];
        assign t  = sq[2*MW-1:MW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                frac_reg[k+1] <= {frac_reg[k][FW-2:0], t[MW]};
                ip_reg[k+1]   <= ip_reg[k];
            end
        end

        if (k < FW - 1)
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k+1] <= t[MW] ? t[MW:1] : t[MW-1:0];
                end
            end
        end
    end

    assign result = {ip_reg[FW], frac_reg[FW]};

endmodule

### rtl/csm_div_pipe.sv
// Restoring divider pipeline that resolves one quotient bit per stage.
module csm_div_pipe #(
    parameter int DEN_W  = 32,
    parameter int STEPS  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [STEPS-1:0]  in_bits,
    input  logic [DEN_W-1:0]  in_den,
    output logic              out_vld,
    output logic [SIDE_W-1:0] out_side,
    output logic [STEPS-1:0]  out_quot
);
    logic              vld_reg  [0:STEPS];
    logic [SIDE_W-1:0] side_reg [0:STEPS];
    logic [STEPS-1:0]  quot_reg [0:STEPS];
    logic [DEN_W-1:0]  rem_reg  [0:STEPS-1];
    logic [DEN_W-1:0]  den_reg  [0:STEPS-1];
    logic [STEPS-1:0]  bits_reg [0:STEPS-1];

    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;
    assign quot_reg[0] = '0;
    assign rem_reg[0]  = in_rem;
    assign den_reg[0]  = in_den;
    assign bits_reg[0] = in_bits;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k], bits_reg[k][STEPS-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                quot_reg[k+1] <= {quot_reg[k][STEPS-2:0], ge};
            end
        end

        if (k < STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[k+1]  <= den_reg[k];
                    bits_reg[k+1] <= {bits_reg[k][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[STEPS];
    assign out_side = side_reg[STEPS];
    assign out_quot = quot_reg[STEPS];

endmodule

### rtl/color_scale_mapper_unit.sv
// Top level of the pseudocolor mapper: configuration, fraction, quantiser and colour stages.
//
//   Channel  | Direction | Payload
//   samples  | in        | sample_value (Q16.16), sample_valid
//   colors   | out       | red, green, blue, alpha, is_missing
//   cfg_*    | in        | plain register writes, index and 32-bit data
//
// One sample is accepted every cycle while the output is not stalled.
// The latency is set by the log2 squaring chain and the two bit-per-stage dividers.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module color_scale_mapper_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csm_pkg::CFG_DATA_W-1:0]  cfg_data,
    csm_stream_if.sink                      samples,
    csm_stream_if.source                    colors
);
    localparam int SW  = csm_pkg::SAMPLE_W;
    localparam int FW  = csm_pkg::FRAC_W;
    localparam int CW  = csm_pkg::COLOR_W;
    localparam int LW  = csm_pkg::LOG_W;
    localparam int LAT = csm_pkg::LOG_LAT;
    localparam int QW  = FW + 1;
    localparam int SW8 = 8;

    typedef struct packed {
        logic       missing;
        logic [1:0] kind;
    } frac_side_t;

    typedef struct packed {
        logic          missing;
        logic          quant;
        logic [QW-1:0] f;
    } quant_side_t;

    logic signed [SW-1:0]           range_low_reg;
    logic signed [SW-1:0]           range_high_reg;
    logic                           scale_mode_reg;
    logic [csm_pkg::LEVEL_W-1:0]    levels_reg;
    logic [csm_pkg::MAP_W-1:0]      map_sel_reg;
    logic [csm_pkg::CFG_DATA_W-1:0] missing_color_reg;

    logic advance;

    logic          dl_vld [0:LAT];
    logic [SW-1:0] dl_v   [0:LAT];
    logic          dl_sv  [0:LAT];

    logic [LW-1:0] log_v;
    logic [LW-1:0] log_lo;
    logic [LW-1:0] log_hi;

    logic                 set_vld_reg;
    frac_side_t           set_side_reg;
    logic [SW-1:0]        set_num_reg;
    logic [SW-1:0]        set_den_reg;

    logic                 d1_vld;
    frac_side_t           d1_side;
    logic [QW-1:0]        d1_quot;

    logic                 q1_vld_reg;
    logic                 q1_missing_reg;
    logic [QW-1:0]        q1_f_reg;

    logic                 q2_vld_reg;
    quant_side_t          q2_side_reg;
    logic [SW8-1:0]       q2_q_reg;
    logic [SW8-1:0]       q2_s_reg;

    logic                 d2_vld;
    quant_side_t          d2_side;
    logic [QW-1:0]        d2_quot;

    logic                 c1_vld_reg;
    logic                 c1_missing_reg;
    logic [22:0]          c1_t_reg [0:2];
    logic                 c2_vld_reg;
    logic                 c2_missing_reg;
    logic [14:0]          c2_z_reg [0:2];

    logic                 out_vld_reg;
    csm_pkg::out_item_t   out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg     <= '0;
            range_high_reg    <= SW'(65536);
            scale_mode_reg    <= 1'b0;
            levels_reg        <= '0;
            map_sel_reg       <= csm_pkg::MAP_VIRIDIS;
            missing_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csm_pkg::REG_RANGE_LOW:  range_low_reg     <= cfg_data[SW-1:0];
                csm_pkg::REG_RANGE_HIGH: range_high_reg    <= cfg_data[SW-1:0];
                csm_pkg::REG_SCALE_MODE: scale_mode_reg    <= cfg_data[0];
                csm_pkg::REG_LEVELS:     levels_reg        <= cfg_data[csm_pkg::LEVEL_W-1:0];
                csm_pkg::REG_MAP_SELECT: map_sel_reg       <= cfg_data[csm_pkg::MAP_W-1:0];
                csm_pkg::REG_MISSING:    missing_color_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign advance       = !out_vld_reg || colors.ready;
    assign samples.ready = advance;

    // Input register and delay line that keeps samples beside their log2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
            begin
                dl_vld[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            dl_vld[0] <= samples.valid;
            for (int i = 1; i <= LAT; i++)
            begin
                dl_vld[i] <= dl_vld[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dl_v[0]  <= samples.payload.sample_value;
            dl_sv[0] <= samples.payload.sample_valid;
            for (int i = 1; i <= LAT; i++)
            begin
                dl_v[i]  <= dl_v[i-1];
                dl_sv[i] <= dl_sv[i-1];
            end
        end
    end

    csm_log2 u_log_v  (.clk(clk), .en(advance), .x(dl_v[0]),        .result(log_v));
    csm_log2 u_log_lo (.clk(clk), .en(advance), .x(range_low_reg),  .result(log_lo));
    csm_log2 u_log_hi (.clk(clk), .en(advance), .x(range_high_reg), .result(log_hi));

    frac_side_t    frac_side_in;
    logic [SW-1:0] num_in;
    logic [SW-1:0] den_in;

    // Range test and divider set-up.
    always_comb
    begin
        logic signed [SW-1:0] v;
        logic signed [LW-1:0] lv;
        logic signed [LW-1:0] ll;
        logic signed [LW-1:0] lh;
        frac_side_t           side;
        logic [SW-1:0]        num;
        logic [SW-1:0]        den;
        v  = dl_v[LAT];
        lv = log_v;
        ll = log_lo;
        lh = log_hi;
        side.missing = !dl_sv[LAT] || (range_high_reg <= range_low_reg);
        side.kind    = csm_pkg::KIND_DIV;
        num          = SW'(v - range_low_reg);
        den          = SW'(range_high_reg - range_low_reg);
        if (!scale_mode_reg)
        begin
            if (v <= range_low_reg)
            begin
                side.kind = csm_pkg::KIND_ZERO;
            end
            else if (v >= range_high_reg)
            begin
                side.kind = csm_pkg::KIND_ONE;
            end
        end
        else
        begin
            if (v <= 0 || range_low_reg <= 0 || lh <= ll)
            begin
                side.missing = 1'b1;
            end
            num = SW'(unsigned'(LW'(lv - ll)));
            den = SW'(unsigned'(LW'(lh - ll)));
            if (lv <= ll)
            begin
                side.kind = csm_pkg::KIND_ZERO;
            end
            else if (lv >= lh)
            begin
                side.kind = csm_pkg::KIND_ONE;
            end
        end
        frac_side_in = side;
        num_in       = num;
        den_in       = den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            set_vld_reg <= dl_vld[LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            set_side_reg <= frac_side_in;
            set_num_reg  <= num_in;
            set_den_reg  <= den_in;
        end
    end

    csm_div_pipe #(
        .DEN_W  (SW),
        .STEPS  (QW),
        .SIDE_W ($bits(frac_side_t))
    ) u_frac_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (set_vld_reg),
        .in_side  (set_side_reg),
        .in_rem   (set_num_reg),
        .in_bits  ('0),
        .in_den   (set_den_reg),
        .out_vld  (d1_vld),
        .out_side (d1_side),
        .out_quot (d1_quot)
    );

    // Fraction rounding, then level quantisation.
    logic [QW:0]     quot_inc;
    logic [QW-1:0]   f_c;
    logic [csm_pkg::LEVEL_W-1:0] n_c;
    logic            quant_c;
    logic [SW8-1:0]  s_c;
    logic [23:0]     qprod_c;

    assign quot_inc = {1'b0, d1_quot} + (QW+1)'(1);

    always_comb
    begin
        unique case (d1_side.kind)
            csm_pkg::KIND_ZERO: f_c = '0;
            csm_pkg::KIND_ONE:  f_c = QW'(1) << FW;
            default:            f_c = quot_inc[QW:1];
        endcase
    end

    assign n_c     = (levels_reg > csm_pkg::LEVEL_W'(csm_pkg::MAX_LEVELS))
                     ? csm_pkg::LEVEL_W'(csm_pkg::MAX_LEVELS) : levels_reg;
    assign quant_c = n_c >= csm_pkg::LEVEL_W'(2);
    assign s_c     = SW8'(n_c - csm_pkg::LEVEL_W'(1));
    assign qprod_c = 24'(q1_f_reg) * 24'(s_c) + 24'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            q1_vld_reg <= d1_vld;
            q2_vld_reg <= q1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_missing_reg      <= d1_side.missing;
            q1_f_reg            <= f_c;
            q2_side_reg.missing <= q1_missing_reg;
            q2_side_reg.quant   <= quant_c;
            q2_side_reg.f       <= q1_f_reg;
            q2_q_reg            <= qprod_c[23:16];
            q2_s_reg            <= s_c;
        end
    end

    logic [23:0] lvl_num;
    assign lvl_num = {q2_q_reg, 16'd0} + 24'(q2_s_reg >> 1);

    csm_div_pipe #(
        .DEN_W  (SW8),
        .STEPS  (QW),
        .SIDE_W ($bits(quant_side_t))
    ) u_level_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (q2_vld_reg),
        .in_side  (q2_side_reg),
        .in_rem   ({1'b0, lvl_num[23:17]}),
        .in_bits  (lvl_num[16:0]),
        .in_den   (q2_s_reg),
        .out_vld  (d2_vld),
        .out_side (d2_side),
        .out_quot (d2_quot)
    );

    // Colour blend: endpoint interpolation, scaling to full range, division by one hundred.
    csm_pkg::blend_t blend;
    logic [QW-1:0]   f2;
    logic [22:0]     t_c [0:2];

    assign blend = csm_pkg::map_blend(map_sel_reg);
    assign f2    = d2_side.quant ? d2_quot : d2_side.f;

    always_comb
    begin
        logic [csm_pkg::PCT_W-1:0] a [0:2];
        logic [csm_pkg::PCT_W-1:0] b [0:2];
        logic signed [7:0]         diff;
        logic signed [QW:0]        fs;
        logic signed [25:0]        prod;
        logic signed [25:0]        sum;
        a[0] = blend.lo_end.r;
        a[1] = blend.lo_end.g;
        a[2] = blend.lo_end.b;
        b[0] = blend.hi_end.r;
        b[1] = blend.hi_end.g;
        b[2] = blend.hi_end.b;
        fs   = signed'({1'b0, f2});
        for (int ch = 0; ch < 3; ch++)
        begin
            diff    = signed'({1'b0, b[ch]}) - signed'({1'b0, a[ch]});
            prod    = diff * fs;
            sum     = signed'(26'({a[ch], 16'd0})) + prod;
            t_c[ch] = sum[22:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            c1_vld_reg  <= d2_vld;
            c2_vld_reg  <= c1_vld_reg;
            out_vld_reg <= c2_vld_reg;
        end
    end

    logic [CW-1:0] chan_c [0:2];

    always_comb
    begin
        logic [30:0] y;
        for (int ch = 0; ch < 3; ch++)
        begin
            y          = 31'(c2_z_reg[ch]) * 31'(41944);
            chan_c[ch] = y[29:22];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [30:0] x;
        if (advance)
        begin
            c1_missing_reg <= d2_side.missing;
            c2_missing_reg <= c1_missing_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                c1_t_reg[ch] <= t_c[ch];
                x            = 31'(c1_t_reg[ch]) * 31'(255) + 31'(3276800);
                c2_z_reg[ch] <= x[30:16];
            end
            if (c2_missing_reg)
            begin
                out_reg.red        <= missing_color_reg[31:24];
                out_reg.green      <= missing_color_reg[23:16];
                out_reg.blue       <= missing_color_reg[15:8];
                out_reg.alpha      <= missing_color_reg[7:0];
                out_reg.is_missing <= 1'b1;
            end
            else
            begin
                out_reg.red        <= chan_c[0];
                out_reg.green      <= chan_c[1];
                out_reg.blue       <= chan_c[2];
                out_reg.alpha      <= '1;
                out_reg.is_missing <= 1'b0;
            end
        end
    end

    assign colors.valid   = out_vld_reg;
    assign colors.payload = out_reg;

`ifndef SYNTH
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready == (!colors.valid || colors.ready))
        else $error("input ready does not follow the output stall");

    a_mapped_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && !colors.payload.is_missing) |-> (colors.payload.alpha == '1))
        else $error("mapped colour is not opaque");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && !colors.ready) |=> $stable(c2_vld_reg) && $stable(q1_vld_reg))
        else $error("pipeline moved during an output stall");
`endif

endmodule
